// ===== rtl/lcg_range_or_list_picker_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Picker assertion macros
// Shared concurrent assertion forms for the picker RTL.
// ----------------------------------------------------------------------------
`ifndef LCG_RANGE_OR_LIST_PICKER_UNIT_MACROS_SVH
`define LCG_RANGE_OR_LIST_PICKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LRLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// Picker package
// Types, codes and constants shared by the picker modules.
// ----------------------------------------------------------------------------
package lrlp_pkg;

    localparam int LIST_MAX = 64;
    localparam int LIST_AW  = $clog2(LIST_MAX);
    localparam int CNT_W    = $clog2(LIST_MAX + 1);

    localparam logic [31:0] LCG_MUL = 32'd472940017;
    localparam logic [31:0] LCG_ADD = 32'd832416023;

    // arg_count value that selects the inclusive range; above it is list mode
    localparam logic [6:0] ARG_INCL = 7'd2;

    typedef enum logic [1:0] {
        OP_DRAW = 2'd0,
        OP_SEED = 2'd1,
        OP_LOAD = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_ARG_COUNT   = 2'd0,
        CFG_LOWER_BOUND = 2'd1,
        CFG_UPPER_BOUND = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic adv;
        logic seed;
        logic wr_entry;
        logic scale;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic list_mode;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/lrlp_ram.sv =====
// ----------------------------------------------------------------------------
// Picker RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lrlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lrlp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Picker controller
// Sequences one item at a time: advance, scale, list read, result write.
// ----------------------------------------------------------------------------
`include "lcg_range_or_list_picker_unit_macros.svh"

module lrlp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    op,
    input  lrlp_pkg::sts_t sts,
    output lrlp_pkg::cmd_t cmd
);

    lrlp_pkg::state_t state_reg;
    lrlp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrlp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrlp_pkg::ST_IDLE:
            begin
                if (in_valid && (op == lrlp_pkg::OP_DRAW))
                begin
                    state_next = lrlp_pkg::ST_SCALE;
                end
            end
            lrlp_pkg::ST_SCALE:
            begin
                state_next = sts.list_mode ? lrlp_pkg::ST_READ : lrlp_pkg::ST_WRITE;
            end
            lrlp_pkg::ST_READ:
            begin
                state_next = lrlp_pkg::ST_WRITE;
            end
            lrlp_pkg::ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    state_next = lrlp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrlp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            lrlp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (op)
                        lrlp_pkg::OP_DRAW: cmd.adv      = 1'b1;
                        lrlp_pkg::OP_SEED: cmd.seed     = 1'b1;
                        lrlp_pkg::OP_LOAD: cmd.wr_entry = 1'b1;
                        default:           ;
                    endcase
                end
            end
            lrlp_pkg::ST_SCALE:
            begin
                cmd.scale = 1'b1;
            end
            lrlp_pkg::ST_READ:
            begin
            end
            lrlp_pkg::ST_WRITE:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

    `LRLP_ASSERT_IMPL(a_load_needs_room, clk, rst_n, cmd.load_out, sts.out_free,
        "result written while output register is occupied")
    `LRLP_ASSERT_NEXT(a_draw_goes_scale, clk, rst_n, in_valid && in_ready && (op == lrlp_pkg::OP_DRAW),
        state_reg == lrlp_pkg::ST_SCALE, "draw item did not move to scaling")
    `LRLP_ASSERT_NEXT(a_scale_exit, clk, rst_n, state_reg == lrlp_pkg::ST_SCALE,
        (state_reg == lrlp_pkg::ST_READ) || (state_reg == lrlp_pkg::ST_WRITE),
        "scaling step not followed by read or write")
    `LRLP_ASSERT_NEXT(a_read_to_write, clk, rst_n, state_reg == lrlp_pkg::ST_READ,
        state_reg == lrlp_pkg::ST_WRITE, "list read not followed by result write")

endmodule

// ===== rtl/lrlp_dp.sv =====
// ----------------------------------------------------------------------------
// Picker datapath
// Generator state, configuration, shared scaling multiplier, list RAM and
// output register.
// ----------------------------------------------------------------------------
module lrlp_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [1:0]          cfg_index,
    input  logic [25:0]         cfg_data,
    input  logic [31:0]         seed_word,
    input  logic [5:0]          entry_index,
    input  logic [31:0]         entry_word,
    input  lrlp_pkg::cmd_t      cmd,
    output lrlp_pkg::sts_t      sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [25:0]  number,
    output logic [31:0]         picked_word,
    output logic                from_list,
    output logic [31:0]         new_state
);

    logic [6:0]         arg_count_reg;
    logic signed [25:0] lower_bound_reg;
    logic signed [25:0] upper_bound_reg;
    logic [31:0]        lcg_state_reg;
    logic [31:0]        lcg_state_next;
    logic signed [60:0] prod_reg;
    logic               out_valid_reg;
    logic [25:0]        number_reg;
    logic [31:0]        picked_reg;
    logic               from_list_reg;
    logic [31:0]        new_state_reg;

    logic                         list_mode;
    logic                         incl_mode;
    logic [lrlp_pkg::CNT_W-1:0]   list_cnt;
    logic signed [25:0]           lo;
    logic signed [26:0]           n;
    logic                         b;
    logic signed [27:0]           n_ext;
    logic signed [27:0]           range;
    logic signed [27:0]           mult_a;
    logic signed [60:0]           mult;
    logic [25:0]                  number_calc;
    logic [lrlp_pkg::LIST_AW-1:0] list_idx;
    logic [31:0]                  ram_rdata;
    logic                         ram_we;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_count_reg   <= '0;
            lower_bound_reg <= '0;
            upper_bound_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                lrlp_pkg::CFG_ARG_COUNT:   arg_count_reg   <= cfg_data[6:0];
                lrlp_pkg::CFG_LOWER_BOUND: lower_bound_reg <= cfg_data;
                lrlp_pkg::CFG_UPPER_BOUND: upper_bound_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Advance on a draw, load on a seed
    assign lcg_state_next = lcg_state_reg * lrlp_pkg::LCG_MUL + lrlp_pkg::LCG_ADD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_state_reg <= '0;
        end
        else if (cmd.seed)
        begin
            lcg_state_reg <= seed_word;
        end
        else if (cmd.adv)
        begin
            lcg_state_reg <= lcg_state_next;
        end
    end

    // Mode and range terms, all from configuration
    assign list_mode = arg_count_reg > lrlp_pkg::ARG_INCL;
    assign incl_mode = arg_count_reg == lrlp_pkg::ARG_INCL;
    assign list_cnt  = (32'(arg_count_reg) > lrlp_pkg::LIST_MAX)
                     ? lrlp_pkg::CNT_W'(lrlp_pkg::LIST_MAX)
                     : lrlp_pkg::CNT_W'(arg_count_reg);
    assign lo        = incl_mode ? lower_bound_reg : 26'sd0;
    assign n         = {upper_bound_reg[25], upper_bound_reg} - {lo[25], lo};
    assign b         = n[26];
    assign n_ext     = {n[26], n};

    always_comb
    begin
        if (incl_mode)
        begin
            range = b ? (n_ext - 28'sd1) : (n_ext + 28'sd1);
        end
        else
        begin
            range = (n == 27'sd0) ? 28'sd1 : n_ext;
        end
    end

    // One multiplier serves both the range scale and the list index
    assign mult_a = list_mode ? $signed(28'(list_cnt)) : range;
    assign mult   = mult_a * $signed({1'b0, lcg_state_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            prod_reg <= mult;
        end
    end

    // Upper word of the product is the floored quotient by 2^32
    assign number_calc = prod_reg[57:32] + lo + {25'd0, b};
    assign list_idx    = prod_reg[32 +: lrlp_pkg::LIST_AW];
    assign ram_we      = cmd.wr_entry && (32'(entry_index) < lrlp_pkg::LIST_MAX);

    lrlp_ram #(
        .WIDTH (32),
        .DEPTH (lrlp_pkg::LIST_MAX)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (lrlp_pkg::LIST_AW'(entry_index)),
        .wdata (entry_word),
        .raddr (list_idx),
        .rdata (ram_rdata)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            number_reg    <= list_mode ? 26'd0 : number_calc;
            picked_reg    <= list_mode ? ram_rdata : 32'd0;
            from_list_reg <= list_mode;
            new_state_reg <= lcg_state_reg;
        end
    end

    assign sts.list_mode = list_mode;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign number      = $signed(number_reg);
    assign picked_word = picked_reg;
    assign from_list   = from_list_reg;
    assign new_state   = new_state_reg;

endmodule

// ===== rtl/lcg_range_or_list_picker_unit.sv =====
// ----------------------------------------------------------------------------
// LCG range or list picker
// 32-bit linear congruential generator that draws a bounded integer or
// picks one stored list word on every draw item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item per handshake: op draw
//   advances the generator and yields one result item; op seed loads the
//   generator state; op load writes entry_word into list slot entry_index.
//   Seed, load and the unused op code give no result.
//   Output channel (out_valid/out_ready) carries number, picked_word,
//   from_list and new_state through one output register.
//   Configuration (cfg_wen/cfg_index/cfg_data) writes arg_count, lower_bound
//   or upper_bound, one per write; write only while the block is idle.
// Sequence: an accepted draw advances the generator, the scale step then
//   registers the product, list mode adds the registered list RAM read,
//   and the write step loads the output register. One draw is in flight
//   at a time: the next item is accepted after the write step, which waits
//   until the output register is free. Seed and load finish on acceptance.
// Reset: generator state, configuration and out_valid clear to zero; the
//   list holds no data until written. If the receiver stalls, the result
//   holds in the output register and the next item is accepted; a
//   following draw waits in its write step until the register frees.
// ----------------------------------------------------------------------------
module lcg_range_or_list_picker_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wen,
    input  logic [1:0]         cfg_index,
    input  logic [25:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [31:0]        seed_word,
    input  logic [5:0]         entry_index,
    input  logic [31:0]        entry_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [25:0] number,
    output logic [31:0]        picked_word,
    output logic               from_list,
    output logic [31:0]        new_state
);

    lrlp_pkg::cmd_t cmd;
    lrlp_pkg::sts_t sts;

    // Sequencer: accept, advance, scale, read, write
    lrlp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Generator, multiplier, list storage and result register
    lrlp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .seed_word   (seed_word),
        .entry_index (entry_index),
        .entry_word  (entry_word),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .number      (number),
        .picked_word (picked_word),
        .from_list   (from_list),
        .new_state   (new_state)
    );

endmodule
